// ----- hdl/hit_map_tree_encoder_defines.svh -----
// Assertion macros shared by the hit map tree encoder.
`ifndef HIT_MAP_TREE_ENCODER_DEFINES_SVH
`define HIT_MAP_TREE_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HMTE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hmte check failed: label");

// The consequent must hold in the cycle after the antecedent.
`define HMTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hmte check failed: label");

`endif

// ----- hdl/hmte_pkg.sv -----
package hmte_pkg;

    localparam int HitMapW  = 16;
    localparam int CodeW    = 30;
    localparam int LenW     = 5;
    localparam int CountW   = 5;
    // Fifteen tree nodes can emit a pair; one more empty slot fills the merge tree.
    localparam int NumSlots = 16;

    // Pair value written as {first emitted bit, second emitted bit}.
    localparam logic [1:0] PairShort = 2'b01;

    typedef struct packed {
        logic       en;
        logic [1:0] pair;
    } t_slot;

    typedef t_slot [NumSlots-1:0] t_slot_vec;

endpackage

// ----- hdl/hmte_if.sv -----
interface hmte_in_if;
    logic                           valid;
    logic                           ready;
    logic [hmte_pkg::HitMapW-1:0]   hit_map;

    modport source (output valid, output hit_map, input ready);
    modport sink   (input valid, input hit_map, output ready);
endinterface

interface hmte_out_if;
    logic                           valid;
    logic                           ready;
    logic [hmte_pkg::CodeW-1:0]     code_bits;
    logic [hmte_pkg::LenW-1:0]      code_length;
    logic [hmte_pkg::CountW-1:0]    hit_count;

    modport source (output valid, output code_bits, output code_length,
                    output hit_count, input ready);
    modport sink   (input valid, input code_bits, input code_length,
                    input hit_count, output ready);
endinterface

// ----- hdl/hmte_pairs.sv -----
module hmte_pairs (
    input  logic [hmte_pkg::HitMapW-1:0] i_map,
    output hmte_pkg::t_slot_vec          o_slots,
    output logic [hmte_pkg::CountW-1:0]  o_hit_count
);
    import hmte_pkg::*;

    logic [1:0] sum2 [8];
    logic [2:0] sum3 [4];
    logic [3:0] sum4 [2];
    logic [3:0] nib;
    logic [1:0] pix;

    // Slots are listed in emission order: level 1, level 2, level 3, level 4.
    always_comb begin
        o_slots = '0;
        o_slots[0].en   = 1'b1;
        o_slots[0].pair = {|i_map[7:0], |i_map[15:8]};
        nib = '0;
        pix = '0;
        for (int h = 0; h < 2; h++) begin
            o_slots[1+h].en   = |i_map[8*h +: 8];
            o_slots[1+h].pair = {|i_map[8*h +: 4], |i_map[8*h+4 +: 4]};
            for (int r = 0; r < 2; r++) begin
                nib = i_map[8*h+4*r +: 4];
                o_slots[3+2*h+r].en   = |nib;
                o_slots[3+2*h+r].pair = {|nib[1:0], |nib[3:2]};
                for (int j = 0; j < 2; j++) begin
                    pix = nib[2*j +: 2];
                    // The left (lower index) pixel is emitted first.
                    o_slots[7+4*h+2*r+j].en   = |pix;
                    o_slots[7+4*h+2*r+j].pair = {pix[0], pix[1]};
                end
            end
        end
    end

    // Population count as a small adder tree.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sum2[i] = {1'b0, i_map[2*i]} + {1'b0, i_map[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            sum3[i] = {1'b0, sum2[2*i]} + {1'b0, sum2[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            sum4[i] = {1'b0, sum3[2*i]} + {1'b0, sum3[2*i+1]};
        end
        o_hit_count = {1'b0, sum4[0]} + {1'b0, sum4[1]};
    end

endmodule

// ----- hdl/hmte_pack.sv -----
module hmte_pack (
    input  hmte_pkg::t_slot_vec         i_slots,
    output logic [hmte_pkg::CodeW-1:0]  o_code,
    output logic [hmte_pkg::LenW-1:0]   o_len
);
    import hmte_pkg::*;

    logic [CodeW-1:0] c0 [16];
    logic [LenW-1:0]  l0 [16];
    logic [CodeW-1:0] c1 [8];
    logic [LenW-1:0]  l1 [8];
    logic [CodeW-1:0] c2 [4];
    logic [LenW-1:0]  l2 [4];
    logic [CodeW-1:0] c3 [2];
    logic [LenW-1:0]  l3 [2];

    // Each slot becomes a short bit string; the pair 01 shrinks to a single 0.
    always_comb begin
        for (int i = 0; i < NumSlots; i++) begin
            if (!i_slots[i].en) begin
                c0[i] = '0;
                l0[i] = '0;
            end else if (i_slots[i].pair == PairShort) begin
                c0[i] = '0;
                l0[i] = LenW'(1);
            end else begin
                c0[i] = CodeW'(i_slots[i].pair);
                l0[i] = LenW'(2);
            end
        end
    end

    // Four merge levels: the earlier string moves up by the later one's length.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            c1[i] = (c0[2*i] << l0[2*i+1]) | c0[2*i+1];
            l1[i] = LenW'(l0[2*i] + l0[2*i+1]);
        end
        for (int i = 0; i < 4; i++) begin
            c2[i] = (c1[2*i] << l1[2*i+1]) | c1[2*i+1];
            l2[i] = LenW'(l1[2*i] + l1[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            c3[i] = (c2[2*i] << l2[2*i+1]) | c2[2*i+1];
            l3[i] = LenW'(l2[2*i] + l2[2*i+1]);
        end
        o_code = (c3[0] << l3[1]) | c3[1];
        o_len  = LenW'(l3[0] + l3[1]);
    end

endmodule

// ----- hdl/hit_map_tree_encoder.sv -----
// A hit map is accepted into the input register and moves on into the result register, which drives the result port.
// Throughput: one hit map per cycle while the sink keeps up; the input register feeds the encoding logic,
// which feeds the result register, and both advance whenever the result is taken or empty.
// Reset (synchronous, active low) clears only the two stage valid flags; payload
// registers are left as they are, and the block holds no other state.
`include "hit_map_tree_encoder_defines.svh"

module hit_map_tree_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hmte_in_if.sink    i_in,
    hmte_out_if.source o_out
);
    import hmte_pkg::*;

    // Stage one holds the raw map, stage two holds the finished result.
    logic               r_s1_valid;
    logic               n_s1_valid;
    logic [HitMapW-1:0] r_s1_map;
    logic               r_s2_valid;
    logic               n_s2_valid;
    logic [CodeW-1:0]   r_s2_code;
    logic [LenW-1:0]    r_s2_len;
    logic [CountW-1:0]  r_s2_count;

    logic               s2_free;
    logic               s1_take;
    logic               s2_take;
    t_slot_vec          slots;
    logic [CodeW-1:0]   enc_code;
    logic [LenW-1:0]    enc_len;
    logic [CountW-1:0]  enc_count;

    // The result register can take a new value when it is empty or its beat
    // leaves this cycle. The input register in turn can load when it is empty
    // or its content moves on, so a fresh map enters every cycle while the
    // sink keeps up.
    assign s2_free    = !r_s2_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s2_free;
    assign s1_take    = i_in.valid && i_in.ready;
    assign s2_take    = r_s1_valid && s2_free;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s2_valid = r_s2_valid;
        if (i_in.ready) begin
            n_s1_valid = i_in.valid;
        end
        if (s2_free) begin
            n_s2_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_s1_map <= i_in.hit_map;
        end
        if (s2_take) begin
            r_s2_code  <= enc_code;
            r_s2_len   <= enc_len;
            r_s2_count <= enc_count;
        end
    end

    // Tree nodes and their occupancy pairs, plus the hit count.
    hmte_pairs u_pairs (
        .i_map       (r_s1_map),
        .o_slots     (slots),
        .o_hit_count (enc_count)
    );

    // Compression and concatenation of the pairs in emission order.
    hmte_pack u_pack (
        .i_slots (slots),
        .o_code  (enc_code),
        .o_len   (enc_len)
    );

    assign o_out.valid       = r_s2_valid;
    assign o_out.code_bits   = r_s2_code;
    assign o_out.code_length = r_s2_len;
    assign o_out.hit_count   = r_s2_count;

    // An empty map, and only an empty map, gives the two-bit code.
    `HMTE_ASSERT_SAME(a_empty_len, i_clk, i_rst_n, o_out.valid, ((o_out.code_length == LenW'(2)) == (o_out.hit_count == '0)))
    // A full map gives thirty ones.
    `HMTE_ASSERT_SAME(a_full_code, i_clk, i_rst_n, o_out.valid && (o_out.hit_count == CountW'(HitMapW)), (o_out.code_length == LenW'(CodeW)) && (&o_out.code_bits))
    // A map held in the input register is not dropped while the result stalls.
    `HMTE_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s2_free, r_s1_valid && $stable(r_s1_map))
    // A result is loaded only from a valid input stage.
    `HMTE_ASSERT_NEXT(a_s2_src, i_clk, i_rst_n, !r_s1_valid && !r_s2_valid, !r_s2_valid)

endmodule
